>>> rtl/core/i2c_eeprom_transaction_master_unit_macros.svh
// Assertion macros for the EEPROM transaction master checker.
// Included by the checker file only.
`ifndef I2C_EEPROM_TRANSACTION_MASTER_UNIT_MACROS_SVH
`define I2C_EEPROM_TRANSACTION_MASTER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IEM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define IEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/iem_pkg.sv
// Package for the EEPROM transaction master: phase, kind, status, register and slot codes, payload types.
// No dependencies.
package iem_pkg;
   typedef enum logic [4:0] {
      PH_IDLE, PH_W_START, PH_W_DEV, PH_W_ADDR, PH_W_WAIT, PH_W_DATA, PH_W_STOP,
      PH_P_START, PH_P_DEV, PH_P_STOP, PH_R_START, PH_R_DEV, PH_R_ADDR,
      PH_R_RSTART, PH_R_DEVR, PH_R_DATA, PH_E_STOP
   } phase_type;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_DATA  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NACK    = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_ARG     = 2'd3;

   localparam logic [1:0] CSR_DEVICE  = 2'd0;
   localparam logic [1:0] CSR_STRETCH = 2'd1;
   localparam logic [1:0] CSR_POLL    = 2'd2;

   localparam logic [1:0] Q3_KEEP    = 2'd0;
   localparam logic [1:0] Q3_LOW     = 2'd1;
   localparam logic [1:0] Q3_RELEASE = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] mem_address;
      logic [8:0] byte_count;
      logic [7:0] write_byte;
      logic       scl_level;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic [7:0] read_data;
      logic       read_valid;
      logic       want_data;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [10:0] data;
   } csr_type;
endpackage

>>> rtl/core/iem_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on iem_pkg.
interface iem_req_if;
   import iem_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface iem_rsp_if;
   import iem_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface iem_csr_if;
   import iem_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/i2c_eeprom_transaction_master_unit.sv
// A request transfer yields its result in the result register in the next cycle.
// One request per cycle while results drain; the bus state machine steps once per transfer.
// A full result register accepts a new request in the same cycle it is taken.
// Reset (synchronous, active high) sets the idle phase, releases both lines and
// loads the register defaults. No clearing pass is needed.
module i2c_eeprom_transaction_master_unit #(
   parameter int MEM_BYTES  = 256,
   parameter int PAGE_BYTES = 8
) (
   input logic clock,
   input logic reset,
   iem_req_if.sink   req,
   iem_rsp_if.source rsp,
   iem_csr_if.sink   csr
);
   import iem_pkg::*;

   // Registers.
   logic [6:0]  device_ff, stretch_lim_ff;
   logic [10:0] poll_lim_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  q_ff, q_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  addr_ff, addr_in;
   logic [8:0]  rem_ff, rem_in;
   logic [6:0]  sc_ff, sc_in;
   logic [10:0] pc_ff, pc_in;
   logic [1:0]  pend_ff, pend_in;
   logic        scl_ff, scl_in, sda_ff, sda_in;
   logic        rvld_ff;
   rsp_type     out_ff, out_in;

   logic [7:0]  addr_next;
   logic        page_end;

   logic accept;
   assign req.ready = !rvld_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rvld_ff;
   assign rsp.payload = out_ff;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_ff      <= 7'd80;
         stretch_lim_ff <= 7'd100;
         poll_lim_ff    <= 11'd1200;
      end else if (csr.valid) begin
         case (csr.payload.index)
            CSR_DEVICE:  device_ff      <= csr.payload.data[6:0];
            CSR_STRETCH: stretch_lim_ff <= csr.payload.data[6:0];
            CSR_POLL:    poll_lim_ff    <= csr.payload.data;
            default: ;
         endcase
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; q_ff <= '0; bit_ff <= '0; shift_ff <= '0;
         addr_ff <= '0; rem_ff <= '0; sc_ff <= '0; pc_ff <= '0; pend_ff <= '0;
         scl_ff <= 1'b0; sda_ff <= 1'b0; rvld_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in; q_ff <= q_in; bit_ff <= bit_in; shift_ff <= shift_in;
            addr_ff <= addr_in; rem_ff <= rem_in; sc_ff <= sc_in; pc_ff <= pc_in;
            pend_ff <= pend_in; scl_ff <= scl_in; sda_ff <= sda_in;
            rvld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rvld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) out_ff <= out_in;
   end

   // Page boundary test on the address after the current data byte.
   always_comb begin
      addr_next = addr_ff + 8'd1;
      page_end  = 1'b0;
      for (int k = 0; k < 256; k++) begin
         if ((k % PAGE_BYTES) == 0 && addr_next == 8'(k)) page_end = 1'b1;
      end
   end

   // Next state and result for one tick.
   always_comb begin
      req_type    r;
      logic       slot_done, slot_to, q1_low, nxt_bit;
      logic [1:0] q3;
      logic [7:0] dev_w;
      logic [9:0] sum;
      logic       run_slot, nack;
      r = req.payload;
      phase_in = phase_ff; q_in = q_ff; bit_in = bit_ff; shift_in = shift_ff;
      addr_in = addr_ff; rem_in = rem_ff; sc_in = sc_ff; pc_in = pc_ff;
      pend_in = pend_ff; scl_in = scl_ff; sda_in = sda_ff;
      out_in = '0;
      dev_w = {device_ff, 1'b0};
      sum = {2'b0, r.mem_address} + {1'b0, r.byte_count};
      slot_done = 1'b0; slot_to = 1'b0; q1_low = 1'b0; q3 = Q3_KEEP; run_slot = 1'b0;
      nxt_bit = (bit_ff < 4'd8) ? shift_ff[3'd7 - bit_ff[2:0]] : 1'b1;
      nack = r.sda_level;

      // Slot inputs by phase.
      case (phase_ff)
         PH_W_START, PH_R_START, PH_R_RSTART, PH_P_START: begin
            run_slot = 1'b1; q3 = Q3_LOW;
         end
         PH_W_DEV, PH_W_ADDR, PH_W_DATA, PH_R_DEV, PH_R_ADDR, PH_R_DEVR, PH_P_DEV: begin
            run_slot = 1'b1; q1_low = !nxt_bit;
         end
         PH_R_DATA: begin
            run_slot = 1'b1; q1_low = (bit_ff >= 4'd8) && (rem_ff > 9'd1);
         end
         PH_W_STOP, PH_P_STOP, PH_E_STOP: begin
            run_slot = 1'b1; q1_low = 1'b1; q3 = Q3_RELEASE;
         end
         default: ;
      endcase

      // Four-quarter bus slot.
      if (run_slot) begin
         case (q_ff)
            2'd0: begin scl_in = 1'b1; q_in = 2'd1; end
            2'd1: begin sda_in = q1_low; q_in = 2'd2; end
            2'd2: begin scl_in = 1'b0; sc_in = '0; q_in = 2'd3; end
            default: begin
               if (r.scl_level) begin
                  if (q3 == Q3_LOW) sda_in = 1'b1;
                  else if (q3 == Q3_RELEASE) sda_in = 1'b0;
                  sc_in = '0; q_in = 2'd0; slot_done = 1'b1;
               end else if ({1'b0, sc_ff} + 8'd1 >= {1'b0, stretch_lim_ff}) begin
                  sc_in = '0; q_in = 2'd0; slot_to = 1'b1;
               end else begin
                  sc_in = sc_ff + 7'd1;
               end
            end
         endcase
      end

      case (phase_ff)
         PH_IDLE: begin
            if (r.kind == KIND_WRITE || r.kind == KIND_READ) begin
               if (r.byte_count == 9'd0 || sum > 10'(MEM_BYTES)) begin
                  out_in.done_res = 1'b1; out_in.status = ST_ARG;
               end else begin
                  addr_in = r.mem_address; rem_in = r.byte_count; pend_in = ST_OK;
                  pc_in = '0; sc_in = '0; q_in = '0; bit_in = '0;
                  phase_in = (r.kind == KIND_WRITE) ? PH_W_START : PH_R_START;
               end
            end
         end
         PH_W_START, PH_R_START, PH_R_RSTART, PH_P_START: begin
            if (slot_to) begin
               pend_in = ST_TIMEOUT; phase_in = PH_E_STOP; bit_in = '0;
            end else if (slot_done) begin
               shift_in = (phase_ff == PH_R_RSTART) ? (dev_w | 8'd1) : dev_w;
               bit_in = '0;
               case (phase_ff)
                  PH_W_START:  phase_in = PH_W_DEV;
                  PH_R_START:  phase_in = PH_R_DEV;
                  PH_R_RSTART: phase_in = PH_R_DEVR;
                  default:     phase_in = PH_P_DEV;
               endcase
            end
         end
         PH_W_DEV, PH_W_ADDR, PH_W_DATA, PH_R_DEV, PH_R_ADDR, PH_R_DEVR, PH_P_DEV: begin
            if (slot_to) begin
               pend_in = ST_TIMEOUT; phase_in = PH_E_STOP; bit_in = '0;
            end else if (slot_done && bit_ff < 4'd8) begin
               bit_in = bit_ff + 4'd1;
            end else if (slot_done) begin
               bit_in = '0;
               if (nack && phase_ff != PH_P_DEV) begin
                  pend_in = ST_NACK; phase_in = PH_E_STOP;
               end else begin
                  case (phase_ff)
                     PH_W_DEV: begin shift_in = addr_ff; phase_in = PH_W_ADDR; end
                     PH_R_DEV: begin shift_in = addr_ff; phase_in = PH_R_ADDR; end
                     PH_W_ADDR: phase_in = PH_W_WAIT;
                     PH_R_ADDR: phase_in = PH_R_RSTART;
                     PH_R_DEVR: phase_in = PH_R_DATA;
                     PH_W_DATA: begin
                        addr_in = addr_next; rem_in = rem_ff - 9'd1;
                        phase_in = (rem_ff == 9'd1 || page_end) ? PH_W_STOP : PH_W_WAIT;
                     end
                     default: begin
                        pend_in = nack ? ST_NACK : ST_OK; phase_in = PH_P_STOP;
                     end
                  endcase
               end
            end
         end
         PH_W_WAIT: begin
            if (r.kind == KIND_DATA) begin
               shift_in = r.write_byte; phase_in = PH_W_DATA; q_in = '0; bit_in = '0;
            end
         end
         PH_R_DATA: begin
            if (slot_to) begin
               pend_in = ST_TIMEOUT; phase_in = PH_E_STOP; bit_in = '0;
            end else if (slot_done && bit_ff < 4'd8) begin
               shift_in = {shift_ff[6:0], r.sda_level}; bit_in = bit_ff + 4'd1;
            end else if (slot_done) begin
               bit_in = '0;
               out_in.read_valid = 1'b1; out_in.read_data = shift_ff;
               rem_in = rem_ff - 9'd1;
               if (rem_ff == 9'd1) begin
                  pend_in = ST_OK; phase_in = PH_E_STOP;
               end
            end
         end
         PH_W_STOP, PH_P_STOP, PH_E_STOP: begin
            if (slot_done || slot_to) begin
               sda_in = 1'b0; bit_in = '0; q_in = '0;
               if (phase_ff == PH_W_STOP) begin
                  pc_in = '0; phase_in = PH_P_START;
               end else if (phase_ff == PH_E_STOP) begin
                  out_in.done_res = 1'b1; out_in.status = pend_ff;
                  pend_in = ST_OK; phase_in = PH_IDLE;
               end else if (pend_ff == ST_OK) begin
                  if (rem_ff == 9'd0) begin
                     out_in.done_res = 1'b1; phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_W_START;
                  end
               end else if ({1'b0, pc_ff} + 12'd1 >= {1'b0, poll_lim_ff}) begin
                  out_in.done_res = 1'b1; out_in.status = ST_TIMEOUT;
                  pend_in = ST_OK; phase_in = PH_IDLE;
               end else begin
                  pc_in = pc_ff + 11'd1; phase_in = PH_P_START;
               end
            end
         end
         default: begin
            scl_in = 1'b0; sda_in = 1'b0; phase_in = PH_IDLE; q_in = '0; bit_in = '0;
         end
      endcase

      out_in.scl_pull_low = scl_in;
      out_in.sda_pull_low = sda_in;
      out_in.want_data    = (phase_in == PH_W_WAIT);
      out_in.busy_res     = (phase_in != PH_IDLE);
   end
endmodule

>>> rtl/core/iem_checker.sv
// Port-level checker for the EEPROM transaction master, bound to the top level.
// Depends on iem_pkg and the assertion macro header.
`include "i2c_eeprom_transaction_master_unit_macros.svh"
module iem_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input iem_pkg::rsp_type rsp_payload
);
   import iem_pkg::*;
   `IEM_ASSERT_NEXT(a_rsp_after_req, clock, reset, req_valid && req_ready, rsp_valid, "no result after a transfer")
   `IEM_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty result register")
   `IEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while waiting")
   `IEM_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_payload.done_res, !rsp_payload.busy_res, "done while still busy")
   `IEM_ASSERT_IMP(a_want_busy, clock, reset, rsp_valid && rsp_payload.want_data, rsp_payload.busy_res && !rsp_payload.done_res, "byte requested while idle")
endmodule

bind i2c_eeprom_transaction_master_unit iem_checker u_iem_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

>>> bench/i2c_eeprom_transaction_master_unit_tb.sv
// Self-checking bench for the EEPROM transaction master: directed rows and transactions, then
// random bus traffic under several handshake pressure phases, checked by the table or a local bus predictor.
// Depends on iem_pkg, the channel interfaces in iem_if.sv and the unit itself.
`timescale 1ns / 1ps

module i2c_eeprom_transaction_master_unit_tb;
   import iem_pkg::*;

   localparam int MEM_SIZE   = 256;
   localparam int PAGE_SIZE  = 8;
   localparam int CYCLE_CAP  = 600000;
   localparam int RAND_ITEMS = 800;

   typedef enum logic [1:0] {SLOT_BUSY, SLOT_END, SLOT_LATE} slot_code;
   typedef enum logic [1:0] {OCTET_BUSY, OCTET_ACK, OCTET_LATE, OCTET_NACK} octet_code;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } vector_row;

   logic clock;
   logic reset;

   iem_req_if req ();
   iem_rsp_if rsp ();
   iem_csr_if csr ();

   i2c_eeprom_transaction_master_unit dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source),
      .csr  (csr.sink)
   );

   // Bus predictor state and its copy of the registers.
   phase_type   ph;
   logic [1:0]  qstep;
   logic [3:0]  bit_pos;
   logic [7:0]  shifter;
   logic [7:0]  cur_addr;
   logic [8:0]  remain;
   logic [6:0]  stretch_cnt;
   logic [10:0] poll_cnt;
   logic [1:0]  pend;
   logic        scl_drv;
   logic        sda_drv;
   logic [6:0]  dev_addr;
   logic [6:0]  stretch_lim;
   logic [10:0] poll_lim;

   rsp_type bus_results[$];
   int      cycles;
   int      fails;
   int      n_items;
   int      n_rsp, n_bytes_in, n_ok, n_nack, n_late, n_arg;
   int      sender_idle_pct;
   int      receiver_stall_pct;
   bit      long_hold;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One four-quarter bus slot: pull SCL, set SDA, release SCL, wait for SCL high.
   function automatic slot_code slot_step(bit q1_low, logic [1:0] q3, bit scl);
      case (qstep)
         2'd0: begin
            scl_drv = 1'b1;
            qstep = 2'd1;
            return SLOT_BUSY;
         end
         2'd1: begin
            sda_drv = q1_low;
            qstep = 2'd2;
            return SLOT_BUSY;
         end
         2'd2: begin
            scl_drv = 1'b0;
            stretch_cnt = '0;
            qstep = 2'd3;
            return SLOT_BUSY;
         end
         default: begin
            if (scl) begin
               if (q3 == Q3_LOW) sda_drv = 1'b1;
               else if (q3 == Q3_RELEASE) sda_drv = 1'b0;
               stretch_cnt = '0;
               qstep = 2'd0;
               return SLOT_END;
            end
            if (int'(stretch_cnt) + 1 >= int'(stretch_lim)) begin
               stretch_cnt = '0;
               qstep = 2'd0;
               return SLOT_LATE;
            end
            stretch_cnt = stretch_cnt + 7'd1;
            return SLOT_BUSY;
         end
      endcase
   endfunction

   function automatic octet_code send_octet(bit scl, bit sda);
      bit       b;
      slot_code r;
      b = 1'b1;
      if (bit_pos < 8) b = shifter[7 - bit_pos];
      r = slot_step(!b, Q3_KEEP, scl);
      if (r == SLOT_LATE) begin
         bit_pos = '0;
         return OCTET_LATE;
      end
      if (r == SLOT_BUSY) return OCTET_BUSY;
      if (bit_pos < 8) begin
         bit_pos++;
         return OCTET_BUSY;
      end
      bit_pos = '0;
      return sda ? OCTET_NACK : OCTET_ACK;
   endfunction

   function automatic octet_code recv_octet(bit scl, bit sda);
      slot_code r;
      r = slot_step((bit_pos >= 8) && (remain > 1), Q3_KEEP, scl);
      if (r == SLOT_LATE) begin
         bit_pos = '0;
         return OCTET_LATE;
      end
      if (r == SLOT_BUSY) return OCTET_BUSY;
      if (bit_pos < 8) begin
         shifter = {shifter[6:0], sda};
         bit_pos++;
         return OCTET_BUSY;
      end
      bit_pos = '0;
      return OCTET_ACK;
   endfunction

   function automatic void enter(phase_type p);
      ph = p;
      qstep = '0;
      bit_pos = '0;
   endfunction

   function automatic void abort_with(logic [1:0] s);
      pend = s;
      enter(PH_E_STOP);
   endfunction

   function automatic void predictor_reset();
      dev_addr = 7'd80;
      stretch_lim = 7'd100;
      poll_lim = 11'd1200;
      enter(PH_IDLE);
      shifter = '0;
      cur_addr = '0;
      remain = '0;
      stretch_cnt = '0;
      poll_cnt = '0;
      pend = '0;
      scl_drv = 1'b0;
      sda_drv = 1'b0;
   endfunction

   // Advance the predictor by one tick and return the expected result.
   function automatic rsp_type bus_tick(req_type t);
      rsp_type   o;
      slot_code  s;
      octet_code b;
      logic [7:0] dev_w;
      o = '0;
      dev_w = {dev_addr, 1'b0};
      case (ph)
         PH_IDLE: begin
            if (t.kind == KIND_WRITE || t.kind == KIND_READ) begin
               if (t.byte_count == 0 || int'(t.mem_address) + int'(t.byte_count) > MEM_SIZE) begin
                  o.done_res = 1'b1;
                  o.status = ST_ARG;
               end else begin
                  cur_addr = t.mem_address;
                  remain = t.byte_count;
                  pend = ST_OK;
                  poll_cnt = '0;
                  stretch_cnt = '0;
                  enter(t.kind == KIND_WRITE ? PH_W_START : PH_R_START);
               end
            end
         end
         PH_W_START, PH_R_START, PH_R_RSTART, PH_P_START: begin
            s = slot_step(1'b0, Q3_LOW, t.scl_level);
            if (s == SLOT_LATE) begin
               abort_with(ST_TIMEOUT);
            end else if (s == SLOT_END) begin
               shifter = (ph == PH_R_RSTART) ? (dev_w | 8'd1) : dev_w;
               enter(ph == PH_W_START ? PH_W_DEV : ph == PH_R_START ? PH_R_DEV :
                     ph == PH_R_RSTART ? PH_R_DEVR : PH_P_DEV);
            end
         end
         PH_W_DEV, PH_W_ADDR, PH_W_DATA, PH_R_DEV, PH_R_ADDR, PH_R_DEVR, PH_P_DEV: begin
            b = send_octet(t.scl_level, t.sda_level);
            if (b == OCTET_LATE) begin
               abort_with(ST_TIMEOUT);
            end else if (b == OCTET_NACK && ph != PH_P_DEV) begin
               abort_with(ST_NACK);
            end else if (b != OCTET_BUSY) begin
               if (ph == PH_W_DEV || ph == PH_R_DEV) begin
                  shifter = cur_addr;
                  enter(ph == PH_W_DEV ? PH_W_ADDR : PH_R_ADDR);
               end else if (ph == PH_W_ADDR) begin
                  enter(PH_W_WAIT);
               end else if (ph == PH_R_ADDR) begin
                  enter(PH_R_RSTART);
               end else if (ph == PH_R_DEVR) begin
                  enter(PH_R_DATA);
               end else if (ph == PH_W_DATA) begin
                  cur_addr = cur_addr + 8'd1;
                  remain = remain - 9'd1;
                  enter((remain == 0 || cur_addr % PAGE_SIZE == 0) ? PH_W_STOP : PH_W_WAIT);
               end else begin
                  pend = (b == OCTET_ACK) ? ST_OK : ST_NACK;
                  enter(PH_P_STOP);
               end
            end
         end
         PH_W_WAIT: begin
            if (t.kind == KIND_DATA) begin
               shifter = t.write_byte;
               enter(PH_W_DATA);
            end
         end
         PH_R_DATA: begin
            b = recv_octet(t.scl_level, t.sda_level);
            if (b == OCTET_LATE) begin
               abort_with(ST_TIMEOUT);
            end else if (b == OCTET_ACK) begin
               o.read_valid = 1'b1;
               o.read_data = shifter;
               remain = remain - 9'd1;
               if (remain == 0) abort_with(ST_OK);
            end
         end
         PH_W_STOP, PH_P_STOP, PH_E_STOP: begin
            s = slot_step(1'b1, Q3_RELEASE, t.scl_level);
            if (s != SLOT_BUSY) begin
               sda_drv = 1'b0;
               if (ph == PH_W_STOP) begin
                  poll_cnt = '0;
                  enter(PH_P_START);
               end else if (ph == PH_E_STOP) begin
                  o.done_res = 1'b1;
                  o.status = pend;
                  pend = ST_OK;
                  enter(PH_IDLE);
               end else if (pend == ST_OK) begin
                  if (remain == 0) begin
                     o.done_res = 1'b1;
                     enter(PH_IDLE);
                  end else begin
                     enter(PH_W_START);
                  end
               end else if (int'(poll_cnt) + 1 >= int'(poll_lim)) begin
                  o.done_res = 1'b1;
                  o.status = ST_TIMEOUT;
                  pend = ST_OK;
                  enter(PH_IDLE);
               end else begin
                  poll_cnt = poll_cnt + 11'd1;
                  enter(PH_P_START);
               end
            end
         end
         default: begin
            scl_drv = 1'b0;
            sda_drv = 1'b0;
            enter(PH_IDLE);
         end
      endcase
      o.scl_pull_low = scl_drv;
      o.sda_pull_low = sda_drv;
      o.want_data = (ph == PH_W_WAIT);
      o.busy_res = (ph != PH_IDLE);
      return o;
   endfunction

   // Offer one request; the predictor steps at the edge of the transfer.
   task automatic offer(req_type t, bit typed, rsp_type want);
      rsp_type predicted;
      req.valid <= 1'b1;
      req.payload <= t;
      do @(posedge clock); while (!req.ready);
      n_items++;
      predicted = bus_tick(t);
      bus_results.push_back(typed ? want : predicted);
      if (($urandom_range(0, 99) < sender_idle_pct) && !long_hold) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic req_type tick_item(bit scl, bit sda);
      req_type t;
      t = '0;
      t.kind = KIND_TICK;
      t.scl_level = scl;
      t.sda_level = sda;
      return t;
   endfunction

   // Random item, shaped by where the predictor stands so transactions run deep.
   function automatic req_type random_item(int scl_high_pct);
      req_type t;
      int      n;
      t.mem_address = 8'($urandom_range(0, 255));
      t.byte_count = 9'($urandom_range(0, 511));
      t.write_byte = 8'($urandom_range(0, 255));
      t.kind = 2'($urandom_range(0, 3));
      t.scl_level = ($urandom_range(0, 99) < scl_high_pct);
      t.sda_level = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 8) return t;
      if (ph == PH_IDLE) begin
         t.kind = ($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ;
         if ($urandom_range(0, 99) < 90) begin
            n = $urandom_range(1, 12);
            t.byte_count = 9'(n);
            t.mem_address = 8'($urandom_range(0, MEM_SIZE - n));
         end
      end else if (ph == PH_W_WAIT) begin
         t.kind = ($urandom_range(0, 99) < 60) ? KIND_DATA : KIND_TICK;
      end else begin
         t.kind = ($urandom_range(0, 99) < 85) ? KIND_TICK : 2'($urandom_range(1, 3));
      end
      return t;
   endfunction

   // Run the current transaction to its end with a cooperative bus, then let results drain.
   task automatic settle();
      req_type t;
      while (ph != PH_IDLE) begin
         t = tick_item(1'b1, 1'b0);
         if (ph == PH_W_WAIT) begin
            t.kind = KIND_DATA;
            t.write_byte = 8'($urandom_range(0, 255));
         end
         offer(t, 1'b0, '0);
      end
      req.valid <= 1'b0;
      wait (bus_results.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the caller drops valid after the last one.
   task automatic write_csr(logic [1:0] idx, logic [10:0] val);
      csr.valid <= 1'b1;
      csr.payload <= '{index: idx, data: val};
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CSR_DEVICE:  dev_addr = val[6:0];
         CSR_STRETCH: stretch_lim = val[6:0];
         CSR_POLL:    poll_lim = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(int d, int s, int p);
      write_csr(CSR_DEVICE, 11'(d));
      write_csr(CSR_STRETCH, 11'(s));
      write_csr(CSR_POLL, 11'(p));
      csr.valid <= 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold-off counted here.
   initial begin
      int held;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp.ready <= 1'b0;
            for (held = 0; held < 300; held++) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp.ready <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Result checker: each transfer against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (!reset && rsp.valid && rsp.ready) begin
         a = rsp.payload;
         if (bus_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", a);
            fails++;
         end else begin
            e = bus_results.pop_front();
            n_rsp++;
            if (a.scl_pull_low !== e.scl_pull_low) begin
               $error("scl_pull_low: expected %0d, got %0d", e.scl_pull_low, a.scl_pull_low);
               fails++;
            end
            if (a.sda_pull_low !== e.sda_pull_low) begin
               $error("sda_pull_low: expected %0d, got %0d", e.sda_pull_low, a.sda_pull_low);
               fails++;
            end
            if (a.read_data !== e.read_data) begin
               $error("read_data: expected %0h, got %0h", e.read_data, a.read_data);
               fails++;
            end
            if (a.read_valid !== e.read_valid) begin
               $error("read_valid: expected %0d, got %0d", e.read_valid, a.read_valid);
               fails++;
            end
            if (a.want_data !== e.want_data) begin
               $error("want_data: expected %0d, got %0d", e.want_data, a.want_data);
               fails++;
            end
            if (a.busy_res !== e.busy_res) begin
               $error("busy_res: expected %0d, got %0d", e.busy_res, a.busy_res);
               fails++;
            end
            if (a.done_res !== e.done_res) begin
               $error("done_res: expected %0d, got %0d", e.done_res, a.done_res);
               fails++;
            end
            if (a.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, a.status);
               fails++;
            end
            if (e.read_valid) n_bytes_in++;
            if (e.done_res) begin
               case (e.status)
                  ST_OK:      n_ok++;
                  ST_NACK:    n_nack++;
                  ST_TIMEOUT: n_late++;
                  default:    n_arg++;
               endcase
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("i2c_eeprom_transaction_master_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      vector_row rows[$];
      vector_row v;
      rsp_type   z;
      int        k;
      int        pass_no;
      int        rand_base;
      cycles = 0;
      fails = 0;
      n_items = 0;
      long_hold = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      csr.valid <= 1'b0;
      csr.payload <= '0;
      predictor_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: ignored kinds, argument errors, then a short write with a read offered while busy.
      z = '0;
      v.typed = 1'b1;
      v.want = z;
      v.item = '{KIND_TICK, 8'd0, 9'd0, 8'd0, 1'b1, 1'b1};
      rows.push_back(v);
      v.item = '{KIND_DATA, 8'hff, 9'h1ff, 8'hff, 1'b0, 1'b0};
      rows.push_back(v);
      v.want.done_res = 1'b1;
      v.want.status = ST_ARG;
      v.item = '{KIND_WRITE, 8'd0, 9'd0, 8'h00, 1'b1, 1'b1};
      rows.push_back(v);
      v.item = '{KIND_READ, 8'd1, 9'd256, 8'hff, 1'b1, 1'b0};
      rows.push_back(v);
      v.item = '{KIND_WRITE, 8'hff, 9'd2, 8'h00, 1'b0, 1'b1};
      rows.push_back(v);
      v.item = '{KIND_READ, 8'd0, 9'h1ff, 8'h00, 1'b1, 1'b1};
      rows.push_back(v);
      v.want = z;
      v.want.busy_res = 1'b1;
      v.item = '{KIND_WRITE, 8'd254, 9'd2, 8'h00, 1'b1, 1'b0};
      rows.push_back(v);
      // Read while busy must be ignored.
      v.typed = 1'b0;
      v.item = '{KIND_READ, 8'd0, 9'd1, 8'h00, 1'b1, 1'b0};
      rows.push_back(v);
      foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].want);
      settle();
      // Read ending on the last byte of memory, every byte acknowledged except the last.
      offer('{KIND_READ, 8'd252, 9'd4, 8'h00, 1'b1, 1'b0}, 1'b0, z);
      settle();
      // Address NACK on the device byte, then a stretched clock with a tight limit.
      offer('{KIND_WRITE, 8'd3, 9'd5, 8'h00, 1'b1, 1'b1}, 1'b0, z);
      for (k = 0; k < 60 && ph != PH_IDLE; k++) offer(tick_item(1'b1, 1'b1), 1'b0, z);
      settle();
      set_regs(0, 1, 1);
      offer('{KIND_READ, 8'd7, 9'd3, 8'h00, 1'b1, 1'b0}, 1'b0, z);
      for (k = 0; k < 12 && ph != PH_IDLE; k++) offer(tick_item(1'b0, 1'b0), 1'b0, z);
      settle();

      // Random phases over register settings and handshake pressure.
      rand_base = n_items;
      for (pass_no = 0; pass_no < 6; pass_no++) begin
         case (pass_no)
            0: set_regs(80, 100, 1200);
            1: set_regs(127, 127, 2047);
            2: set_regs(0, 3, 1);
            3: set_regs($urandom_range(0, 127), 4, 3);
            4: set_regs($urandom_range(0, 127), $urandom_range(2, 127), $urandom_range(1, 2047));
            default: set_regs(85, 6, 2);
         endcase
         sender_idle_pct = (pass_no % 4 == 1 || pass_no % 4 == 3) ? 81 : 0;
         receiver_stall_pct = (pass_no % 4 == 2 || pass_no % 4 == 3) ? 81 : 0;
         if (pass_no % 4 == 3) begin
            sender_idle_pct = 19;
            receiver_stall_pct = 19;
         end
         if (pass_no == 4) long_hold = 1'b1;
         for (k = 0; k < 40 || n_items < rand_base + RAND_ITEMS * (pass_no + 1) / 6; k++) begin
            offer(random_item(pass_no >= 2 ? 80 : 95), 1'b0, z);
            if (k == 20) begin
               // Sender pause until every expected result is back.
               req.valid <= 1'b0;
               wait (bus_results.size() == 0);
               @(posedge clock);
            end
         end
         settle();
      end

      req.valid <= 1'b0;
      wait (bus_results.size() == 0);
      repeat (8) @(posedge clock);
      $display("Checked %0d result transfers, %0d read bytes.", n_rsp, n_bytes_in);
      $display("Transactions ended: ok %0d, nack %0d, timeout %0d, bad request %0d.",
               n_ok, n_nack, n_late, n_arg);
      if (fails == 0) begin
         $display("i2c_eeprom_transaction_master_unit_tb: done, clean");
      end else begin
         $display("i2c_eeprom_transaction_master_unit_tb: done, errors");
      end
      $finish;
   end
endmodule
